// ----- design/ugrb_pkg.sv -----
`default_nettype none
package ugrb_pkg;

    // Batch store geometry
    localparam int BATCH_DEPTH = 32;
    localparam int ADDR_W      = $clog2(BATCH_DEPTH);
    localparam int FILL_W      = $clog2(BATCH_DEPTH + 1);
    localparam int IDX_W       = FILL_W + 1;

    // Field widths
    localparam int WORD_W     = 32;
    localparam int TS_W       = 64;
    localparam int CNT_W      = 32;
    localparam int GROUP_W    = 4;
    localparam int MSG_LEN_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 6;

    localparam int LIMIT_MIN = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_GROUP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DEST_GROUP   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIMIT  = CFG_IDX_W'(3);

    // Groupless message types
    localparam logic [3:0] MT_UTILITY = 4'h0;
    localparam logic [3:0] MT_STREAM  = 4'hF;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FLUSH_EARLY,
        SEQ_FLUSH_END
    } seq_state_t;

    typedef struct packed {
        logic              issue;
        logic [ADDR_W-1:0] addr;
        logic              last;
        logic [TS_W-1:0]   ts;
        logic [CNT_W-1:0]  rcv;
        logic [CNT_W-1:0]  fwd;
    } rd_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } wr_req_t;

    // UMP words per message, by message type
    function automatic logic [MSG_LEN_W-1:0] msg_len(input logic [3:0] mt);
        logic [MSG_LEN_W-1:0] len;
        case (mt)
            4'h0, 4'h1, 4'h2, 4'h6, 4'h7: len = MSG_LEN_W'(1);
            4'h3, 4'h4, 4'h8, 4'h9, 4'hA: len = MSG_LEN_W'(2);
            4'hB, 4'hC:                   len = MSG_LEN_W'(3);
            default:                      len = MSG_LEN_W'(4);
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ----- design/ump_group_route_batcher_core.sv -----
`default_nettype none
// Throughput: one input beat per cycle while no batch is emitted; a flush holds
//   off input while its words are read out, and the reads wait while m_tready
//   is low (one RAM read port, one word a cycle).
// Flush path: the first word of a flush reaches m_tvalid through the sequencer
//   state register, the RAM read register and the output register.
// Reset: synchronous, active low; clears parser, fill, counters and pipeline.
//   Batch RAM contents are left undefined; only written entries are read.
module ump_group_route_batcher_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // word [31:0], timestamp [95:32]
    input  wire logic [95:0] s_tdata,
    // delivery_end
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_word [31:0], out_timestamp [95:32], received_count [127:96],
    // forwarded_count [159:128]
    output logic [159:0]     m_tdata,
    // run_last
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [5:0]  cfg_data
);

    localparam int FILL_W = ugrb_pkg::FILL_W;
    localparam int IDX_W  = ugrb_pkg::IDX_W;
    localparam int ADDR_W = ugrb_pkg::ADDR_W;
    localparam int LEN_W  = ugrb_pkg::MSG_LEN_W;

    // ---------------- configuration registers ----------------
    logic                             enable_reg;
    logic [ugrb_pkg::GROUP_W-1:0]     src_grp_reg, dst_grp_reg;
    logic [ugrb_pkg::CFG_DATA_W-1:0]  limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            src_grp_reg <= '0;
            dst_grp_reg <= '0;
            limit_reg   <= ugrb_pkg::CFG_DATA_W'(32);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ugrb_pkg::REG_ENABLE:       enable_reg  <= cfg_data[0];
                ugrb_pkg::REG_SOURCE_GROUP: src_grp_reg <= cfg_data[3:0];
                ugrb_pkg::REG_DEST_GROUP:   dst_grp_reg <= cfg_data[3:0];
                ugrb_pkg::REG_BATCH_LIMIT:  limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- state ----------------
    ugrb_pkg::seq_state_t state_reg, state_next;

    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [LEN_W-1:0]           left_reg, left_next;
    logic [LEN_W-1:0]           mlen_reg, mlen_next;
    logic                       kept_reg, kept_next;
    logic [ugrb_pkg::CNT_W-1:0] rcv_reg, rcv_next;
    logic [ugrb_pkg::CNT_W-1:0] fwd_reg, fwd_next;

    logic [FILL_W-1:0]          rd_idx_reg, rd_idx_next;
    logic [FILL_W-1:0]          rd_cnt_reg, rd_cnt_next;
    logic [FILL_W-1:0]          f2_cnt_reg, f2_cnt_next;
    logic                       end_pend_reg, end_pend_next;
    logic [ugrb_pkg::TS_W-1:0]  ts_reg, ts_next;

    // write held back until an early flush has read the old batch out
    logic                        pw_en_reg, pw_en_next;
    logic [ADDR_W-1:0]           pw_addr_reg, pw_addr_next;
    logic [ugrb_pkg::WORD_W-1:0] pw_data_reg, pw_data_next;

    // ---------------- input decode ----------------
    logic [ugrb_pkg::WORD_W-1:0] in_word, wword;
    logic [ugrb_pkg::TS_W-1:0]   in_ts;
    logic                        in_end;
    logic                        accept, step;
    logic [3:0]                  mt;
    logic                        first, grouped, hdr_kept, kept_now;
    logic [LEN_W-1:0]            len, mlen, left0, left1;
    logic [FILL_W-1:0]           limit_eff, fill_base, fill_new;
    logic [IDX_W-1:0]            sum, widx;
    logic                        flush_early, go_early, wr_ok, complete;

    assign in_word = s_tdata[31:0];
    assign in_ts   = s_tdata[95:32];
    assign in_end  = s_tlast;

    assign s_tready = (state_reg == ugrb_pkg::SEQ_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign step     = accept && enable_reg;

    always_comb begin
        // limit saturated to 4..depth
        if (limit_reg < ugrb_pkg::CFG_DATA_W'(ugrb_pkg::LIMIT_MIN)) begin
            limit_eff = FILL_W'(ugrb_pkg::LIMIT_MIN);
        end else if (limit_reg > ugrb_pkg::CFG_DATA_W'(ugrb_pkg::BATCH_DEPTH)) begin
            limit_eff = FILL_W'(ugrb_pkg::BATCH_DEPTH);
        end else begin
            limit_eff = FILL_W'(limit_reg);
        end

        mt       = in_word[31:28];
        len      = ugrb_pkg::msg_len(mt);
        first    = (left_reg == '0);
        grouped  = (mt != ugrb_pkg::MT_UTILITY) && (mt != ugrb_pkg::MT_STREAM);
        hdr_kept = grouped && (in_word[27:24] == src_grp_reg);
        kept_now = first ? hdr_kept : kept_reg;
        mlen     = first ? len : mlen_reg;
        left0    = first ? len : left_reg;

        // overflow check made on the header word of a kept message
        sum         = IDX_W'(fill_reg) + IDX_W'(len);
        flush_early = first && hdr_kept && (sum > IDX_W'(limit_eff));
        go_early    = flush_early && (fill_reg != '0);
        fill_base   = flush_early ? '0 : fill_reg;

        wword = (first && hdr_kept) ? {in_word[31:28], dst_grp_reg, in_word[23:0]}
                                    : in_word;
        widx  = IDX_W'(fill_base) + IDX_W'(LEN_W'(mlen - left0));
        wr_ok = kept_now && (widx < IDX_W'(ugrb_pkg::BATCH_DEPTH));

        left1    = LEN_W'(left0 - LEN_W'(1));
        complete = (left1 == '0);
        fill_new = (complete && kept_now) ? FILL_W'(fill_base + FILL_W'(mlen)) : fill_base;
    end

    // ---------------- sequencer ----------------
    ugrb_pkg::wr_req_t wr;
    ugrb_pkg::rd_req_t rd;
    logic              rd_free;

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        left_next     = left_reg;
        mlen_next     = mlen_reg;
        kept_next     = kept_reg;
        rcv_next      = rcv_reg;
        fwd_next      = fwd_reg;
        rd_idx_next   = rd_idx_reg;
        rd_cnt_next   = rd_cnt_reg;
        f2_cnt_next   = f2_cnt_reg;
        end_pend_next = end_pend_reg;
        ts_next       = ts_reg;
        pw_en_next    = pw_en_reg;
        pw_addr_next  = pw_addr_reg;
        pw_data_next  = pw_data_reg;

        wr.en   = 1'b0;
        wr.addr = widx[ADDR_W-1:0];
        wr.data = wword;

        rd.issue = 1'b0;
        rd.addr  = rd_idx_reg[ADDR_W-1:0];
        rd.last  = (FILL_W'(rd_idx_reg + 1'b1) == rd_cnt_reg);
        rd.ts    = ts_reg;
        rd.rcv   = rcv_reg;
        rd.fwd   = fwd_reg;

        case (state_reg)
            ugrb_pkg::SEQ_IDLE: begin
                if (step) begin
                    left_next     = in_end ? '0 : left1;
                    kept_next     = kept_now && !complete && !in_end;
                    mlen_next     = mlen;
                    rcv_next      = rcv_reg + ugrb_pkg::CNT_W'(complete);
                    fwd_next      = fwd_reg + ugrb_pkg::CNT_W'(complete && kept_now);
                    fill_next     = in_end ? '0 : fill_new;
                    ts_next       = in_ts;
                    f2_cnt_next   = in_end ? fill_new : '0;
                    end_pend_next = in_end;
                    rd_idx_next   = '0;
                    if (go_early) begin
                        pw_en_next   = wr_ok;
                        pw_addr_next = widx[ADDR_W-1:0];
                        pw_data_next = wword;
                        rd_cnt_next  = fill_reg;
                        state_next   = ugrb_pkg::SEQ_FLUSH_EARLY;
                    end else begin
                        wr.en = wr_ok;
                        if (in_end && (fill_new != '0)) begin
                            rd_cnt_next = fill_new;
                            state_next  = ugrb_pkg::SEQ_FLUSH_END;
                        end
                    end
                end
            end
            ugrb_pkg::SEQ_FLUSH_EARLY: begin
                rd.issue = rd_free;
                if (rd_free) begin
                    rd_idx_next = FILL_W'(rd_idx_reg + 1'b1);
                    if (rd.last) begin
                        // last old entry is read this cycle; safe to overwrite
                        wr.en      = pw_en_reg;
                        wr.addr    = pw_addr_reg;
                        wr.data    = pw_data_reg;
                        pw_en_next = 1'b0;
                        if (end_pend_reg && (f2_cnt_reg != '0)) begin
                            rd_idx_next = '0;
                            rd_cnt_next = f2_cnt_reg;
                            state_next  = ugrb_pkg::SEQ_FLUSH_END;
                        end else begin
                            state_next = ugrb_pkg::SEQ_IDLE;
                        end
                    end
                end
            end
            ugrb_pkg::SEQ_FLUSH_END: begin
                rd.issue = rd_free;
                if (rd_free) begin
                    rd_idx_next = FILL_W'(rd_idx_reg + 1'b1);
                    if (rd.last) begin
                        state_next = ugrb_pkg::SEQ_IDLE;
                    end
                end
            end
            default: begin
                state_next = ugrb_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ugrb_pkg::SEQ_IDLE;
            fill_reg     <= '0;
            left_reg     <= '0;
            mlen_reg     <= '0;
            kept_reg     <= 1'b0;
            rcv_reg      <= '0;
            fwd_reg      <= '0;
            rd_idx_reg   <= '0;
            rd_cnt_reg   <= '0;
            f2_cnt_reg   <= '0;
            end_pend_reg <= 1'b0;
            pw_en_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            left_reg     <= left_next;
            mlen_reg     <= mlen_next;
            kept_reg     <= kept_next;
            rcv_reg      <= rcv_next;
            fwd_reg      <= fwd_next;
            rd_idx_reg   <= rd_idx_next;
            rd_cnt_reg   <= rd_cnt_next;
            f2_cnt_reg   <= f2_cnt_next;
            end_pend_reg <= end_pend_next;
            pw_en_reg    <= pw_en_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        ts_reg      <= ts_next;
        pw_addr_reg <= pw_addr_next;
        pw_data_reg <= pw_data_next;
    end

    // ---------------- batch store and output stage ----------------
    ugrb_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .rd       (rd),
        .rd_free  (rd_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ----- design/ugrb_store.sv -----
`default_nettype none
// Batch store RAM, registered read stage and output register.
module ugrb_store (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ugrb_pkg::wr_req_t wr,
    input  wire ugrb_pkg::rd_req_t rd,
    output logic                   rd_free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // out_word, out_timestamp, received_count, forwarded_count
    output logic [159:0]           m_tdata,
    output logic                   m_tlast
);

    logic [ugrb_pkg::WORD_W-1:0] mem [ugrb_pkg::BATCH_DEPTH];

    logic                        rd_valid_reg, rd_valid_next;
    logic [ugrb_pkg::WORD_W-1:0] rd_word_reg;
    logic                        rd_last_reg;
    logic [ugrb_pkg::TS_W-1:0]   rd_ts_reg;
    logic [ugrb_pkg::CNT_W-1:0]  rd_rcv_reg, rd_fwd_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [ugrb_pkg::WORD_W-1:0] out_word_reg;
    logic                        out_last_reg;
    logic [ugrb_pkg::TS_W-1:0]   out_ts_reg;
    logic [ugrb_pkg::CNT_W-1:0]  out_rcv_reg, out_fwd_reg;

    logic take;

    assign take    = !out_valid_reg || m_tready;
    assign rd_free = !rd_valid_reg || take;

    always_comb begin
        rd_valid_next  = rd.issue || (rd_valid_reg && !take);
        out_valid_next = take ? rd_valid_reg : out_valid_reg;
    end

    // read-first: a write and a read of one entry in a cycle return old data
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.issue) begin
            rd_word_reg <= mem[rd.addr];
            rd_last_reg <= rd.last;
            rd_ts_reg   <= rd.ts;
            rd_rcv_reg  <= rd.rcv;
            rd_fwd_reg  <= rd.fwd;
        end
        if (take && rd_valid_reg) begin
            out_word_reg <= rd_word_reg;
            out_last_reg <= rd_last_reg;
            out_ts_reg   <= rd_ts_reg;
            out_rcv_reg  <= rd_rcv_reg;
            out_fwd_reg  <= rd_fwd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_fwd_reg, out_rcv_reg, out_ts_reg, out_word_reg};

endmodule
`default_nettype wire

// ----- design/ugrb_port_checker.sv -----
`default_nettype none
module ugrb_port_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [159:0] m_tdata,
    input wire logic         m_tlast
);

    // output register empties on reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // stalled beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output beat changed");

    // words of one run follow without a gap, same timestamp and counters
    a_run_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tdata[159:32] == $past(m_tdata[159:32]))))
        else $error("run broken or sideband changed within run");

endmodule

bind ump_group_route_batcher_core ugrb_port_checker u_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ----- verif/ugrb_route_monitor.sv -----
`timescale 1ns / 1ps
// Watches the three channels of the batcher, predicts every result beat and
// compares field by field, oldest first.
module ugrb_route_monitor
    import ugrb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [95:0]           s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [159:0]          m_tdata,
    input  wire logic                  m_tlast,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         beats_due
);

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [TS_W-1:0]   ts;
        logic              run_last;
        logic [CNT_W-1:0]  rcv;
        logic [CNT_W-1:0]  fwd;
    } route_beat_t;

    // words per UMP message, indexed by message type
    localparam int UMP_WORDS [16] = '{1, 1, 1, 2, 2, 4, 1, 1, 2, 2, 2, 3, 3, 4, 4, 4};

    logic [WORD_W-1:0]     batch_mem [BATCH_DEPTH];
    int unsigned           batch_fill;
    int unsigned           words_left;
    int unsigned           msg_words;
    bit                    msg_keep;
    logic [CNT_W-1:0]      msgs_seen;
    logic [CNT_W-1:0]      msgs_routed;

    bit                    route_en;
    logic [GROUP_W-1:0]    src_grp;
    logic [GROUP_W-1:0]    dst_grp;
    logic [CFG_DATA_W-1:0] limit_reg;

    route_beat_t           route_beats_due [$];

    initial begin
        mismatches = 0;
        beats_due  = 0;
    end

    // limit register saturated to LIMIT_MIN..BATCH_DEPTH, what the store can hold
    function automatic int unsigned batch_cap();
        int unsigned cap;
        cap = limit_reg;
        if (cap < LIMIT_MIN)
            cap = LIMIT_MIN;
        if (cap > BATCH_DEPTH)
            cap = BATCH_DEPTH;
        return cap;
    endfunction

    task automatic drain_batch(input logic [TS_W-1:0] ts, ref route_beat_t beats [$]);
        route_beat_t b;
        for (int unsigned i = 0; i < batch_fill; i++) begin
            b.word     = batch_mem[i];
            b.ts       = ts;
            b.run_last = (i + 1 == batch_fill);
            b.rcv      = '0;
            b.fwd      = '0;
            beats.push_back(b);
        end
        batch_fill = 0;
    endtask

    task automatic route_word(input logic [WORD_W-1:0] w_in, input logic [TS_W-1:0] ts,
                              input logic endf);
        route_beat_t       step_beats [$];
        logic [WORD_W-1:0] w;
        logic [3:0]        mt;
        int unsigned       idx;
        w = w_in;
        if (!route_en)
            return;
        if (words_left == 0) begin
            mt         = w[31:28];
            msg_words  = UMP_WORDS[mt];
            words_left = msg_words;
            msg_keep   = (mt != MT_UTILITY) && (mt != MT_STREAM) && (w[27:24] == src_grp);
            if (msg_keep) begin
                // flush on the first word, before the message is known complete
                if (batch_fill + msg_words > batch_cap())
                    drain_batch(ts, step_beats);
                w[27:24] = dst_grp;
            end
        end
        if (msg_keep) begin
            idx = batch_fill + msg_words - words_left;
            if (idx < BATCH_DEPTH)
                batch_mem[idx] = w;
        end
        words_left--;
        if (words_left == 0) begin
            msgs_seen++;
            if (msg_keep) begin
                batch_fill += msg_words;
                msgs_routed++;
            end
            msg_keep = 1'b0;
        end
        if (endf) begin
            // cut-off tail is thrown away
            words_left = 0;
            msg_keep   = 1'b0;
            drain_batch(ts, step_beats);
        end
        foreach (step_beats[k]) begin
            step_beats[k].rcv = msgs_seen;
            step_beats[k].fwd = msgs_routed;
            route_beats_due.push_back(step_beats[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [TS_W-1:0] want,
                               input logic [TS_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        route_beat_t b;
        if (!aresetn) begin
            batch_fill  = 0;
            words_left  = 0;
            msg_words   = 0;
            msg_keep    = 1'b0;
            msgs_seen   = '0;
            msgs_routed = '0;
            route_en    = 1'b0;
            src_grp     = '0;
            dst_grp     = '0;
            limit_reg   = CFG_DATA_W'(BATCH_DEPTH);
            route_beats_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ENABLE:       route_en  = cfg_data[0];
                    REG_SOURCE_GROUP: src_grp   = cfg_data[GROUP_W-1:0];
                    REG_DEST_GROUP:   dst_grp   = cfg_data[GROUP_W-1:0];
                    REG_BATCH_LIMIT:  limit_reg = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (route_beats_due.size() == 0) begin
                    $error("result beat with nothing expected: word %08h", m_tdata[31:0]);
                    mismatches++;
                end else begin
                    b = route_beats_due.pop_front();
                    check_field("out_word", b.word, m_tdata[31:0]);
                    check_field("out_timestamp", b.ts, m_tdata[95:32]);
                    check_field("run_last", b.run_last, m_tlast);
                    check_field("received_count", b.rcv, m_tdata[127:96]);
                    check_field("forwarded_count", b.fwd, m_tdata[159:128]);
                end
            end
            if (s_tvalid && s_tready)
                route_word(s_tdata[31:0], s_tdata[95:32], s_tlast);
        end
        beats_due = route_beats_due.size();
    end

endmodule

// ----- verif/ump_group_route_batcher_core_tb.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the UMP group router / batcher. All prediction and
// comparison lives in ugrb_route_monitor.
module ump_group_route_batcher_core_tb;
    import ugrb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on any channel
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 10;    // margin for the flush pipeline to settle
    localparam int PHASE_WORDS    = 50;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [95:0]           s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [159:0]          m_tdata;
    logic                  m_tlast;
    logic                  cfg_ready;

    int                    mismatches;
    int                    beats_due;

    // stimulus-side view of the settings, for shaping traffic only
    bit                    en_shadow   = 1'b0;
    logic [GROUP_W-1:0]    cur_src     = '0;
    bit                    quiet       = 1'b0;  // no idling on either side
    int                    holds_asked = 0;
    int                    words_fed   = 0;     // words sent while enabled
    int                    idle_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    ump_group_route_batcher_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ugrb_route_monitor u_route_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .beats_due  (beats_due)
    );

    // Receiver: random stall bursts, plus one long hold-off on request so the
    // batch store backs up and the input side gets throttled.
    initial begin
        int holds_done;
        int n;
        holds_done = 0;
        forever begin
            @(negedge aclk);
            if (holds_asked > holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: trips only when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One input beat. Valid stays up into the next call when there is no gap.
    task automatic push_word(input logic [31:0] w, input logic [63:0] ts, input bit endf);
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, w};
        s_tlast  <= endf;
        do @(posedge aclk); while (!s_tready);
        if (en_shadow)
            words_fed++;
    endtask

    task automatic in_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    // Wait until every predicted beat is out, then let the pipeline settle
    task automatic drain();
        in_idle();
        while (beats_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_route(input logic [GROUP_W-1:0] src, input logic [GROUP_W-1:0] dst,
                             input logic [CFG_DATA_W-1:0] lim);
        drain();
        cfg_write(REG_SOURCE_GROUP, CFG_DATA_W'(src));
        cfg_write(REG_DEST_GROUP, CFG_DATA_W'(dst));
        cfg_write(REG_BATCH_LIMIT, lim);
        cur_src = src;
    endtask

    // Well-formed delivery of n_msgs messages, mostly on the source group;
    // now and then the last message is cut short by the end flag.
    task automatic send_delivery(input int n_msgs);
        logic [63:0]        ts;
        logic [31:0]        w;
        logic [3:0]         mt;
        logic [GROUP_W-1:0] grp;
        int                 len;
        int                 stop_at;
        bit                 cut;
        bit                 last_msg;
        case ($urandom_range(0, 9))
            0:       ts = '0;
            1:       ts = '1;
            default: ts = {$urandom, $urandom};
        endcase
        cut = ($urandom_range(0, 4) == 0);
        for (int m = 0; m < n_msgs; m++) begin
            mt       = 4'($urandom_range(0, 15));
            grp      = ($urandom_range(0, 9) < 6) ? cur_src : GROUP_W'($urandom_range(0, 15));
            len      = int'(msg_len(mt));
            last_msg = (m == n_msgs - 1);
            stop_at  = len - 1;
            if (last_msg && cut && len > 1)
                stop_at = $urandom_range(0, len - 2);
            for (int j = 0; j < len; j++) begin
                w = $urandom;
                if (j == 0)
                    w[31:24] = {mt, grp};
                push_word(w, ts, last_msg && j == stop_at);
                if (last_msg && j == stop_at)
                    return;
            end
        end
    endtask

    // Unstructured words with scattered end flags
    task automatic send_noise(input int n);
        logic [63:0] ts;
        ts = {$urandom, $urandom};
        for (int i = 0; i < n; i++)
            push_word($urandom, ts, i == n - 1 || $urandom_range(0, 5) == 0);
    endtask

    task automatic run_phase();
        int stop_count;
        int pick;
        stop_count = words_fed + PHASE_WORDS;
        while (words_fed < stop_count) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_noise($urandom_range(1, 8));
            else if (pick == 1)
                send_delivery($urandom_range(9, 16));
            else
                send_delivery($urandom_range(1, 6));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // still disabled out of reset: these beats must vanish
        push_word(32'h45FF_FFFF, 64'h1, 1'b0);
        push_word(32'h2000_0000, 64'h1, 1'b1);

        set_route(4'd5, 4'd10, 6'd4);
        cfg_write(REG_ENABLE, 6'd1);
        en_shadow = 1'b1;

        // limit 4: two kept messages (3 words), groupless utility and stream
        // messages dropped, then a 4-word kept message flushes early and is
        // itself cut off by the end flag
        push_word(32'h45FF_FFFF, 64'h0, 1'b0);
        push_word(32'hFFFF_FFFF, 64'h0, 1'b0);
        push_word(32'h2500_0000, 64'h0, 1'b0);
        push_word(32'h0000_0000, 64'h0, 1'b0);
        push_word(32'hF5FF_FFFF, 64'h0, 1'b0);
        push_word(32'h0000_0000, 64'h0, 1'b0);
        push_word(32'h0000_0000, 64'h0, 1'b0);
        push_word(32'hFFFF_FFFF, 64'h0, 1'b0);
        push_word(32'h55AB_CDEF, 64'h0, 1'b0);
        push_word(32'h1111_1111, 64'h0, 1'b1);

        // other group skipped; 4-word message fills the batch exactly
        push_word(32'h1300_0000, '1, 1'b0);
        push_word(32'hD500_0000, '1, 1'b0);
        push_word(32'h8000_0000, '1, 1'b0);
        push_word(32'h7FFF_FFFF, '1, 1'b0);
        push_word(32'hFFFF_FFFF, '1, 1'b1);

        // 3 + 2 words overflow the limit: early flush, then end flush
        push_word(32'hB5C3_A5F0, 64'h8000_0000_0000_0001, 1'b0);
        push_word(32'h0F0F_0F0F, 64'h8000_0000_0000_0001, 1'b0);
        push_word(32'hF0F0_F0F0, 64'h8000_0000_0000_0001, 1'b0);
        push_word(32'h3512_3456, 64'h8000_0000_0000_0001, 1'b0);
        push_word(32'h789A_BCDE, 64'h8000_0000_0000_0001, 1'b1);

        // random traffic under several settings
        set_route(4'd0, 4'd15, 6'd32);
        run_phase();

        // smallest batches, and the receiver holds off for a long stretch
        // while words keep coming
        set_route(4'd15, 4'd0, 6'd4);
        holds_asked++;
        run_phase();

        // above the store size: saturates to the full depth
        set_route(GROUP_W'($urandom_range(0, 15)), GROUP_W'($urandom_range(0, 15)), 6'd63);
        run_phase();

        // zero limit saturates to the minimum; disable mid-message and resume
        set_route(GROUP_W'($urandom_range(0, 15)), GROUP_W'($urandom_range(0, 15)), 6'd0);
        run_phase();
        push_word({4'h5, cur_src, 24'($urandom)}, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
        drain();
        cfg_write(REG_ENABLE, 6'd0);
        en_shadow = 1'b0;
        send_noise(6);
        drain();
        cfg_write(REG_ENABLE, 6'd1);
        en_shadow = 1'b1;
        run_phase();

        set_route(GROUP_W'($urandom_range(0, 15)), GROUP_W'($urandom_range(0, 15)),
                  CFG_DATA_W'($urandom_range(5, 31)));
        run_phase();

        // final stretch at full rate, no idling anywhere
        set_route(GROUP_W'($urandom_range(0, 15)), GROUP_W'($urandom_range(0, 15)), 6'd3);
        quiet = 1'b1;
        run_phase();

        drain();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- ump_group_route_batcher_core.f -----
design/ugrb_pkg.sv
design/ugrb_store.sv
design/ump_group_route_batcher_core.sv
design/ugrb_port_checker.sv
verif/ugrb_route_monitor.sv
verif/ump_group_route_batcher_core_tb.sv
